// ----- hdl/ccu_pkg.sv -----
// shared constants and codes for the combinatorics count unit
`default_nettype none
package ccu_pkg;

  localparam int OPERAND_BITS = 8;
  localparam int ACTION_W     = 3;
  localparam int COUNT_W      = 64;
  localparam int FACTOR_W     = OPERAND_BITS + 1;
  localparam int DIV_CNT_W    = $clog2(COUNT_W);
  localparam int S_TDATA_W    = ((ACTION_W + 2 * OPERAND_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W    = ((COUNT_W + 7) / 8) * 8;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_FACT   = ACTION_W'(0);
  localparam logic [ACTION_W-1:0] ACT_CHOOSE = ACTION_W'(1);
  localparam logic [ACTION_W-1:0] ACT_FALL   = ACTION_W'(2);
  localparam logic [ACTION_W-1:0] ACT_MULTI  = ACTION_W'(3);
  localparam logic [ACTION_W-1:0] ACT_POWER  = ACTION_W'(4);

endpackage
`default_nettype wire

// ----- hdl/ccu_div.sv -----
// radix-2 restoring divider, 64-bit dividend by a small divisor
`default_nettype none
module ccu_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [ccu_pkg::COUNT_W-1:0]      dividend_i,
  input  wire logic [ccu_pkg::OPERAND_BITS-1:0] divisor_i,
  output logic                                  done_o,
  output logic [ccu_pkg::COUNT_W-1:0]           quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [ccu_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [ccu_pkg::OPERAND_BITS-1:0]  rem_q, rem_d;
  logic [ccu_pkg::OPERAND_BITS-1:0]  dvs_q, dvs_d;
  logic [ccu_pkg::COUNT_W-1:0]       quo_q, quo_d;
  logic [ccu_pkg::OPERAND_BITS:0]    shifted;
  logic                              fits;

  // partial remainder with next dividend bit shifted in
  assign shifted = {rem_q, quo_q[ccu_pkg::COUNT_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? ccu_pkg::OPERAND_BITS'(shifted - {1'b0, dvs_q})
                   : shifted[ccu_pkg::OPERAND_BITS-1:0];
      quo_d = {quo_q[ccu_pkg::COUNT_W-2:0], fits};
      cnt_d = cnt_q + ccu_pkg::DIV_CNT_W'(1);
      if (cnt_q == ccu_pkg::DIV_CNT_W'(ccu_pkg::COUNT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- hdl/combinatorics_count_unit.sv -----
// combinatorics count unit: factorial, choose, falling product, multiset, power
//
// one word in on the s_ channel carries an action code and operands n and k;
// one 64-bit count word comes out on the m_ channel for every word taken in
// the count is a running product over up to n or k steps; each step is a
// multiply on a 64 x 9 bit multiplier, and for choose and multiset it is
// followed by a bit-serial divide by the step index
// s_tready_o is high only while no item is at work, so items are taken one
// at a time; a finished count sits in the output register while the next
// item is already being taken and worked on
// when the receiver stalls, a second finished count waits in the done state
// until the output register frees up
// reset clears the sequencer and the output valid; no count is pending
`default_nettype none
module combinatorics_count_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  // action [2:0], n [10:3], k [18:11], zero pad above
  input  wire logic [ccu_pkg::S_TDATA_W-1:0] s_tdata_i,
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  // count [63:0]
  output logic [ccu_pkg::M_TDATA_W-1:0]      m_tdata_o
);

  localparam int OB = ccu_pkg::OPERAND_BITS;
  localparam int AW = ccu_pkg::ACTION_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [AW-1:0]                  op_q, op_d;
  logic [OB-1:0]                  n_q, n_d;
  logic [OB-1:0]                  idx_q, idx_d;
  logic [OB-1:0]                  steps_q, steps_d;
  logic [ccu_pkg::COUNT_W-1:0]    acc_q, acc_d;
  logic                           out_valid_q, out_valid_d;
  logic [ccu_pkg::COUNT_W-1:0]    out_data_q, out_data_d;

  logic [AW-1:0]                  in_action;
  logic [OB-1:0]                  in_n;
  logic [OB-1:0]                  in_k;
  logic                           in_accept;
  logic                           k_gt_n;
  logic [ccu_pkg::FACTOR_W-1:0]   factor;
  logic [ccu_pkg::COUNT_W-1:0]    product;
  logic                           needs_div;
  logic                           last_step;
  logic                           out_free;
  logic                           div_start;
  logic                           div_done;
  logic [ccu_pkg::COUNT_W-1:0]    div_quot;

  assign in_action = s_tdata_i[AW-1:0];
  assign in_n      = s_tdata_i[AW+OB-1:AW];
  assign in_k      = s_tdata_i[AW+2*OB-1:AW+OB];
  assign in_accept = s_tvalid_i && s_tready_o;
  assign k_gt_n    = in_k > in_n;

  assign s_tready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || m_tready_i;
  assign needs_div  = (op_q == ccu_pkg::ACT_CHOOSE) || (op_q == ccu_pkg::ACT_MULTI);
  assign last_step  = (idx_q == steps_q);

  // multiplier operand for step idx (steps run from 1)
  always_comb begin
    case (op_q)
      ccu_pkg::ACT_FACT:   factor = {1'b0, idx_q};
      ccu_pkg::ACT_CHOOSE,
      ccu_pkg::ACT_FALL:   factor = {1'b0, n_q} - {1'b0, idx_q} + ccu_pkg::FACTOR_W'(1);
      ccu_pkg::ACT_MULTI:  factor = {1'b0, n_q} + {1'b0, idx_q} - ccu_pkg::FACTOR_W'(1);
      ccu_pkg::ACT_POWER:  factor = {1'b0, n_q};
      default:             factor = '0;
    endcase
  end

  // wraps modulo 2^64
  assign product = acc_q * ccu_pkg::COUNT_W'(factor);

  assign div_start = (state_q == ST_MUL) && needs_div;

  ccu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (idx_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    n_d         = n_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d  = in_action;
          n_d   = in_n;
          idx_d = OB'(1);
          acc_d = ccu_pkg::COUNT_W'(1);
          case (in_action)
            ccu_pkg::ACT_FACT:   steps_d = in_n;
            ccu_pkg::ACT_CHOOSE,
            ccu_pkg::ACT_FALL: begin
              steps_d = k_gt_n ? '0 : in_k;
              if (k_gt_n) begin
                acc_d = '0;
              end
            end
            ccu_pkg::ACT_MULTI,
            ccu_pkg::ACT_POWER:  steps_d = in_k;
            default: begin
              steps_d = '0;
              acc_d   = '0;
            end
          endcase
          state_d = (steps_d == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (needs_div) begin
          state_d = ST_DIV;
        end else begin
          acc_d = product;
          if (last_step) begin
            state_d = ST_DONE;
          end else begin
            idx_d = idx_q + OB'(1);
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          acc_d = div_quot;
          if (last_step) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + OB'(1);
            state_d = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      steps_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      steps_q     <= steps_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    n_q        <= n_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = ccu_pkg::M_TDATA_W'(out_data_q);

endmodule
`default_nettype wire

// ----- tb/sv/combinatorics_count_unit_tb.sv -----
// self-checking testbench for the combinatorics count unit
`timescale 1ns / 100ps
`default_nettype none
module combinatorics_count_unit_tb;

  // half clock period, reset length and run limits
  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_WORDS  = 66;
  localparam int PRESSURE_WORDS = 8;
  localparam int LONG_HOLD     = 3000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int REPORT_LIMIT  = 10;
  // worst case is some 100 words at full operand size plus gaps and stalls, taken four times
  localparam longint WATCHDOG_NS = 120_000_000;

  // highest action code; everything above the power code is undefined
  localparam logic [ccu_pkg::ACTION_W-1:0]     ACT_TOP     = '1;
  localparam logic [ccu_pkg::ACTION_W-1:0]     ACT_SPARE_A =
    ccu_pkg::ACT_POWER + ccu_pkg::ACTION_W'(1);
  localparam logic [ccu_pkg::ACTION_W-1:0]     ACT_SPARE_B =
    ccu_pkg::ACT_POWER + ccu_pkg::ACTION_W'(2);
  localparam logic [ccu_pkg::OPERAND_BITS-1:0] OPERAND_MAX = '1;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE} sink_mode_e;

  // one accepted word and the count that it must produce
  typedef struct {
    logic [ccu_pkg::ACTION_W-1:0]     action;
    logic [ccu_pkg::OPERAND_BITS-1:0] n;
    logic [ccu_pkg::OPERAND_BITS-1:0] k;
    logic [ccu_pkg::COUNT_W-1:0]      count;
  } count_entry_t;

  // keeps the counts still owed by the block, in order of acceptance
  class count_scoreboard;
    count_entry_t pending_counts[$];
    int failures;
    int counts_seen;
    int words_per_action[1 << ccu_pkg::ACTION_W];
    int choice_over_set;

    function new();
      failures        = 0;
      counts_seen     = 0;
      choice_over_set = 0;
      foreach (words_per_action[a]) words_per_action[a] = 0;
    endfunction

    // running product wrapping at 64 bits, divides truncating
    function logic [ccu_pkg::COUNT_W-1:0] expected_count(
        logic [ccu_pkg::ACTION_W-1:0] action,
        logic [ccu_pkg::OPERAND_BITS-1:0] n,
        logic [ccu_pkg::OPERAND_BITS-1:0] k);
      logic [ccu_pkg::COUNT_W-1:0] acc;
      int unsigned i;
      acc = 1;
      case (action)
        ccu_pkg::ACT_FACT: begin
          for (i = 2; i <= n; i++) acc = acc * ccu_pkg::COUNT_W'(i);
        end
        ccu_pkg::ACT_CHOOSE: begin
          if (k > n) acc = 0;
          else begin
            for (i = 1; i <= k; i++) begin
              acc = acc * ccu_pkg::COUNT_W'(n - i + 1);
              acc = acc / ccu_pkg::COUNT_W'(i);
            end
          end
        end
        ccu_pkg::ACT_FALL: begin
          if (k > n) acc = 0;
          else begin
            for (i = 0; i < k; i++) acc = acc * ccu_pkg::COUNT_W'(n - i);
          end
        end
        ccu_pkg::ACT_MULTI: begin
          for (i = 1; i <= k; i++) begin
            acc = acc * ccu_pkg::COUNT_W'(n + i - 1);
            acc = acc / ccu_pkg::COUNT_W'(i);
          end
        end
        ccu_pkg::ACT_POWER: begin
          for (i = 0; i < k; i++) acc = acc * ccu_pkg::COUNT_W'(n);
        end
        default: begin
          acc = 0;
        end
      endcase
      return acc;
    endfunction

    function void note_word(logic [ccu_pkg::ACTION_W-1:0] action,
                            logic [ccu_pkg::OPERAND_BITS-1:0] n,
                            logic [ccu_pkg::OPERAND_BITS-1:0] k);
      count_entry_t e;
      e.action = action;
      e.n      = n;
      e.k      = k;
      e.count  = expected_count(action, n, k);
      pending_counts.push_back(e);
      words_per_action[action]++;
      if ((action == ccu_pkg::ACT_CHOOSE || action == ccu_pkg::ACT_FALL) && k > n)
        choice_over_set++;
    endfunction

    function void check_count(logic [ccu_pkg::COUNT_W-1:0] got);
      count_entry_t e;
      counts_seen++;
      if (pending_counts.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: count %h arrived with no word pending", $time, got);
      end else begin
        e = pending_counts.pop_front();
        if (got !== e.count) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("%0t: action %0d n %0d k %0d: count expected %h, got %h",
                     $time, e.action, e.n, e.k, e.count, got);
        end
      end
    endfunction

    function int pending();
      return pending_counts.size();
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_tvalid_i;
  logic                            s_tready_o;
  // action [2:0], n [10:3], k [18:11], zero pad above
  logic [ccu_pkg::S_TDATA_W-1:0]   s_tdata_i;
  logic                            m_tvalid_o;
  logic                            m_tready_i;
  // count [63:0]
  logic [ccu_pkg::M_TDATA_W-1:0]   m_tdata_o;

  count_scoreboard board;
  int  burst_left;
  bit  paced;     // sender idles between bursts when set
  bit  hold_req;  // asks the sink for one long hold-off

  combinatorics_count_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

  // sender idling: random bursts, then a gap of random length with junk on the data lines
  task automatic pace_sender();
    int gap;
    if (!paced) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
      @(negedge clk_i);
      s_tvalid_i = 1'b0;
      s_tdata_i  = ccu_pkg::S_TDATA_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // offer one word and hold it until the block takes it
  task automatic offer_word(input logic [ccu_pkg::ACTION_W-1:0] action,
                            input logic [ccu_pkg::OPERAND_BITS-1:0] n,
                            input logic [ccu_pkg::OPERAND_BITS-1:0] k);
    @(negedge clk_i);
    s_tvalid_i = 1'b1;
    s_tdata_i  = ccu_pkg::S_TDATA_W'({k, n, action});
    do @(posedge clk_i); while (!s_tready_o);
    board.note_word(action, n, k);
    pace_sender();
  endtask

  // sink: takes counts at the rising edge, moves tready at the falling edge
  initial begin : sink
    int hold_left;
    int mode_left;
    int beat;
    sink_mode_e mode;
    hold_left  = 0;
    mode_left  = 0;
    beat       = 0;
    mode       = SINK_OPEN;
    m_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o && m_tready_i) board.check_count(m_tdata_o);
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(int'(SINK_OPEN), int'(SINK_SPARSE)));
        mode_left = $urandom_range(16, 256);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready_i = 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   m_tready_i = 1'b1;
          SINK_COIN:   m_tready_i = 1'($urandom_range(0, 1));
          default:     m_tready_i = (beat % 5 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [ccu_pkg::ACTION_W-1:0]     action;
    logic [ccu_pkg::OPERAND_BITS-1:0] n;
    logic [ccu_pkg::OPERAND_BITS-1:0] k;
    board      = new();
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    burst_left = 0;
    paced      = 1'b1;
    hold_req   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: small factorials, wrap points, k above n, extreme operands
    offer_word(ccu_pkg::ACT_FACT, 0, OPERAND_MAX);
    offer_word(ccu_pkg::ACT_FACT, 1, 0);
    offer_word(ccu_pkg::ACT_FACT, 20, 0);
    offer_word(ccu_pkg::ACT_FACT, 21, 0);            // first wrapping factorial
    offer_word(ccu_pkg::ACT_FACT, OPERAND_MAX, OPERAND_MAX);
    offer_word(ccu_pkg::ACT_CHOOSE, 0, 0);
    offer_word(ccu_pkg::ACT_CHOOSE, 10, 3);
    offer_word(ccu_pkg::ACT_CHOOSE, 3, 5);           // choice larger than set
    offer_word(ccu_pkg::ACT_CHOOSE, OPERAND_MAX, OPERAND_MAX);
    offer_word(ccu_pkg::ACT_CHOOSE, OPERAND_MAX, 128);
    offer_word(ccu_pkg::ACT_FALL, 0, 0);
    offer_word(ccu_pkg::ACT_FALL, 10, 3);
    offer_word(ccu_pkg::ACT_FALL, 4, 7);             // choice larger than set
    offer_word(ccu_pkg::ACT_FALL, OPERAND_MAX, OPERAND_MAX);
    offer_word(ccu_pkg::ACT_MULTI, 0, 0);
    offer_word(ccu_pkg::ACT_MULTI, 0, 5);            // empty set with repetition
    offer_word(ccu_pkg::ACT_MULTI, 4, 3);
    offer_word(ccu_pkg::ACT_MULTI, 1, OPERAND_MAX);
    offer_word(ccu_pkg::ACT_MULTI, OPERAND_MAX, OPERAND_MAX);
    offer_word(ccu_pkg::ACT_POWER, 0, 0);            // zero to the zero
    offer_word(ccu_pkg::ACT_POWER, 0, 3);
    offer_word(ccu_pkg::ACT_POWER, 2, 64);           // wraps to zero
    offer_word(ccu_pkg::ACT_POWER, OPERAND_MAX, OPERAND_MAX);
    offer_word(ACT_SPARE_A, OPERAND_MAX, OPERAND_MAX);
    offer_word(ACT_SPARE_B, 0, 0);
    offer_word(ACT_TOP, 85, 170);

    // pressure: sink holds off while short words keep coming back to back
    paced    = 1'b0;
    hold_req = 1'b1;
    repeat (PRESSURE_WORDS) begin
      offer_word(ccu_pkg::ACT_POWER, ccu_pkg::OPERAND_BITS'($urandom),
                 ccu_pkg::OPERAND_BITS'($urandom_range(0, 8)));
    end
    paced = 1'b1;

    // random: all actions and some undefined codes; choose and multiset runs mostly short, a few at full size
    repeat (RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0)
        action = ccu_pkg::ACTION_W'($urandom_range(int'(ACT_SPARE_A), int'(ACT_TOP)));
      else
        action = ccu_pkg::ACTION_W'($urandom_range(int'(ccu_pkg::ACT_FACT),
                                                   int'(ccu_pkg::ACT_POWER)));
      n = ($urandom_range(0, 4) == 0) ? ccu_pkg::OPERAND_BITS'($urandom_range(0, 15))
                                       : ccu_pkg::OPERAND_BITS'($urandom);
      if ((action == ccu_pkg::ACT_CHOOSE || action == ccu_pkg::ACT_MULTI) &&
          $urandom_range(0, 9) != 0)
        k = ccu_pkg::OPERAND_BITS'($urandom_range(0, 20));
      else
        k = ccu_pkg::OPERAND_BITS'($urandom);
      offer_word(action, n, k);
    end

    // release the input, then let every count drain
    @(negedge clk_i);
    s_tvalid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d counts: factorial %0d, choose %0d, falling %0d, multiset %0d, power %0d",
             board.counts_seen, board.words_per_action[ccu_pkg::ACT_FACT],
             board.words_per_action[ccu_pkg::ACT_CHOOSE],
             board.words_per_action[ccu_pkg::ACT_FALL],
             board.words_per_action[ccu_pkg::ACT_MULTI],
             board.words_per_action[ccu_pkg::ACT_POWER]);
    $display("undefined codes %0d, choice above set %0d, one %0d-cycle output hold, %0d failures",
             board.words_per_action[ACT_SPARE_A] + board.words_per_action[ACT_SPARE_B] +
             board.words_per_action[ACT_TOP], board.choice_over_set, LONG_HOLD, board.failures);
    if (board.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
